@@ hdl/lcs_pkg.sv @@
package lcs_pkg;

  // width of a row score and of the reported length
  localparam int unsigned SCORE_W = 11;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned POSITION_W = 10;
  localparam int unsigned KIND_W = 2;

  // depth of the queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  // item kinds, codes as carried on the input
  typedef enum logic [KIND_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_BYTE   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // one classified item waiting for the back part
  typedef struct packed {
    op_t                   op;
    logic [SYMBOL_W-1:0]   symbol;
    logic [POSITION_W-1:0] position;
  } q_item_t;

  // back part sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_FIN_RD,
    ST_FIN_WAIT
  } back_state_t;

  // status of the back part seen by the top level
  typedef struct packed {
    logic init_done;
    logic fin_capture;
  } back_status_t;

endpackage

@@ hdl/lcs_ram.sv @@
module lcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lcs_front.sv @@
module lcs_front #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                              enable,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lcs_pkg::KIND_W-1:0]        kind,
  input  logic [lcs_pkg::SYMBOL_W-1:0]      symbol,
  input  logic [lcs_pkg::POSITION_W-1:0]    position,
  input  logic                              q_full,
  output logic                              push,
  output lcs_pkg::q_item_t                  push_item
);

  logic keep;

  // accept whenever the queue has room and the row store is initialised
  assign in_ready = enable && !q_full;

  // drop unused kinds and loads beyond the store
  always_comb begin
    keep = 1'b0;
    case (kind)
      lcs_pkg::OP_LOAD:   keep = (32'(position) < 32'(MAX_LEN));
      lcs_pkg::OP_BYTE:   keep = 1'b1;
      lcs_pkg::OP_FINISH: keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;

  always_comb begin
    push_item.op       = lcs_pkg::op_t'(kind);
    push_item.symbol   = symbol;
    push_item.position = position;
  end

endmodule

@@ hdl/lcs_queue.sv @@
module lcs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcs_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lcs_pkg::q_item_t head
);

  localparam int unsigned PTR_W = (lcs_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(lcs_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(lcs_pkg::QUEUE_DEPTH + 1);

  lcs_pkg::q_item_t slots [lcs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(lcs_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hdl/lcs_back.sv @@
module lcs_back #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lcs_pkg::SCORE_W-1:0]     second_length,
  input  logic                            head_valid,
  input  lcs_pkg::q_item_t                head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lcs_pkg::SCORE_W-1:0]     out_data,
  output lcs_pkg::back_status_t           status
);

  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  lcs_pkg::back_state_t state, state_next;

  logic [LEN_W-1:0]             idx;
  logic [LEN_W-1:0]             len_reg;
  logic [LEN_W-1:0]             len_use;
  logic [LEN_W-1:0]             len_m1;
  logic [lcs_pkg::SYMBOL_W-1:0] sym;
  logic                         v1;
  logic [AW-1:0]                a1;
  logic [lcs_pkg::SCORE_W-1:0]  left;
  logic [lcs_pkg::SCORE_W-1:0]  diag;
  logic                         init_done;

  logic                         issue;
  logic                         str_we;
  logic [AW-1:0]                str_waddr;
  logic [lcs_pkg::SYMBOL_W-1:0] str_rdata;
  logic                         row_we;
  logic [AW-1:0]                row_waddr;
  logic [lcs_pkg::SCORE_W-1:0]  row_wdata;
  logic [AW-1:0]                row_raddr;
  logic [lcs_pkg::SCORE_W-1:0]  row_rdata;
  logic [lcs_pkg::SCORE_W-1:0]  up;
  logic [lcs_pkg::SCORE_W-1:0]  cell_score;
  logic                         clear_last;

  // length in use, capped at the store depth
  assign len_use = (32'(second_length) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                        : LEN_W'(second_length);
  assign len_m1     = len_reg - LEN_W'(1);
  assign issue      = (state == lcs_pkg::ST_SWEEP) && (idx < len_reg);
  assign clear_last = (idx == LEN_W'(MAX_LEN - 1));
  assign str_waddr  = AW'(head.position);

  // one row cell: diagonal plus one on a match, else larger of upper and left
  assign up         = row_rdata;
  assign cell_score = (str_rdata == sym) ? (diag + lcs_pkg::SCORE_W'(1))
                                         : ((up > left) ? up : left);

  lcs_ram #(
    .WIDTH (lcs_pkg::SYMBOL_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_str_ram (
    .clk   (clk),
    .we    (str_we),
    .waddr (str_waddr),
    .wdata (head.symbol),
    .raddr (idx[AW-1:0]),
    .rdata (str_rdata)
  );

  lcs_ram #(
    .WIDTH (lcs_pkg::SCORE_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lcs_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_next = lcs_pkg::ST_IDLE;
        end
      end
      lcs_pkg::ST_IDLE: begin
        if (head_valid) begin
          case (head.op)
            lcs_pkg::OP_BYTE:   state_next = lcs_pkg::ST_SWEEP;
            lcs_pkg::OP_FINISH: begin
              if (!out_valid) begin
                state_next = lcs_pkg::ST_FIN_RD;
              end
            end
            default:            state_next = lcs_pkg::ST_IDLE;
          endcase
        end
      end
      lcs_pkg::ST_SWEEP: begin
        if (!issue && !v1) begin
          state_next = lcs_pkg::ST_IDLE;
        end
      end
      lcs_pkg::ST_FIN_RD:   state_next = lcs_pkg::ST_FIN_WAIT;
      lcs_pkg::ST_FIN_WAIT: state_next = lcs_pkg::ST_CLEAR;
      default:              state_next = lcs_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    str_we    = 1'b0;
    row_we    = 1'b0;
    row_waddr = a1;
    row_wdata = cell_score;
    row_raddr = idx[AW-1:0];
    case (state)
      lcs_pkg::ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = idx[AW-1:0];
        row_wdata = '0;
      end
      lcs_pkg::ST_IDLE: begin
        if (head_valid) begin
          case (head.op)
            lcs_pkg::OP_LOAD: begin
              pop    = 1'b1;
              str_we = 1'b1;
            end
            lcs_pkg::OP_FINISH: pop = !out_valid;
            default:            pop = 1'b1;
          endcase
        end
      end
      lcs_pkg::ST_SWEEP: begin
        row_we = v1;
      end
      lcs_pkg::ST_FIN_RD: begin
        row_raddr = len_m1[AW-1:0];
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcs_pkg::ST_CLEAR;
      idx       <= '0;
      v1        <= 1'b0;
      init_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      case (state)
        lcs_pkg::ST_CLEAR: begin
          idx <= clear_last ? '0 : idx + LEN_W'(1);
          if (clear_last) begin
            init_done <= 1'b1;
          end
        end
        lcs_pkg::ST_IDLE:     idx <= '0;
        lcs_pkg::ST_SWEEP: begin
          if (issue) begin
            idx <= idx + LEN_W'(1);
          end
        end
        default:              idx <= '0;
      endcase
      if (state == lcs_pkg::ST_FIN_WAIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      len_reg <= len_use;
      sym     <= head.symbol;
      left    <= '0;
      diag    <= '0;
    end else if (v1) begin
      left <= cell_score;
      diag <= up;
    end
    a1 <= idx[AW-1:0];
    if (state == lcs_pkg::ST_FIN_WAIT) begin
      out_data <= (len_reg == '0) ? '0 : row_rdata;
    end
  end

  assign status.init_done   = init_done;
  assign status.fin_capture = (state == lcs_pkg::ST_FIN_WAIT);

endmodule

@@ hdl/lcs_length_dp_top.sv @@
// a load is written to the string store straight from idle; a first-string byte sweeps
// len row cells (len = second_length capped at MAX_LEN); a finish reads the last row cell,
// registers the result and then clears the row store before the next item is carried out
// throughput is set by the row store sweep: one row cell per cycle
// rst is synchronous; after reset the row store is cleared, during which s_tready
// stays low; second_length resets to 0
module lcs_length_dp_top #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: second_length
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // symbol [7:0], position [17:8], zero fill
  input  logic [1:0]  s_tuser,   // kind [1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // match_length [10:0], zero fill
);

  logic [lcs_pkg::SCORE_W-1:0] second_length;
  logic                        q_full;
  logic                        push;
  lcs_pkg::q_item_t            push_item;
  logic                        pop;
  logic                        head_valid;
  lcs_pkg::q_item_t            head;
  logic [lcs_pkg::SCORE_W-1:0] out_data;
  lcs_pkg::back_status_t       status;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      second_length <= '0;
    end else if (cfg_we) begin
      second_length <= cfg_wdata;
    end
  end

  lcs_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .enable    (status.init_done),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .symbol    (s_tdata[7:0]),
    .position  (s_tdata[17:8]),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lcs_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .second_length (second_length),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (out_data),
    .status        (status)
  );

  assign m_tdata = {5'd0, out_data};

  // no item taken while the row store is still being cleared after reset
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    !status.init_done |-> !s_tready)
    else $error("item accepted before row store initialised");

  // a result appears only after a finish read has been captured
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(status.fin_capture))
    else $error("result raised without a finish read");

  // a finish never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    status.fin_capture |-> !m_tvalid)
    else $error("finish result would overwrite a pending result");

endmodule

@@ tb/sv/lcs_length_dp_top_test.sv @@
module lcs_length_dp_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned SYMBOL_W = lcs_pkg::SYMBOL_W;
  localparam int unsigned POSITION_W = lcs_pkg::POSITION_W;
  localparam int unsigned SCORE_W = lcs_pkg::SCORE_W;
  localparam int unsigned KIND_W = lcs_pkg::KIND_W;
  localparam int CLK_PERIOD = 12;
  // a byte sweep or a finish with its clearing pass, for every item the block may hold
  localparam int unsigned SETTLE_CYCLES = (lcs_pkg::QUEUE_DEPTH + 2) * (MAX_LEN + 8);
  localparam int unsigned LONG_HOLD = 2500;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // lcs length calculation: second string, dp row and the lengths still to be reported
  class lcs_length_calc;
    logic [SYMBOL_W-1:0] second_string [MAX_LEN];
    bit                  loaded [MAX_LEN];
    logic [SCORE_W-1:0]  score_row [MAX_LEN];
    logic [10:0]         length_reg;
    logic [SCORE_W-1:0]  pending_lengths [$];
    int unsigned         mismatches;
    int unsigned         reports;
    int unsigned         loads;
    int unsigned         bytes_swept;
    int unsigned         items_seen;

    function new();
      length_reg = '0;
      mismatches = 0;
      reports = 0;
      loads = 0;
      bytes_swept = 0;
      items_seen = 0;
      foreach (score_row[j]) begin
        score_row[j] = '0;
        second_string[j] = '0;
        loaded[j] = 1'b0;
      end
    endfunction

    // row cells in use, capped at the store depth
    function int unsigned span();
      return (length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg);
    endfunction

    // one pass of the dynamic program over the row for one first-string byte
    function void sweep(logic [SYMBOL_W-1:0] c);
      int unsigned        n;
      logic [SCORE_W-1:0] diag;
      logic [SCORE_W-1:0] left;
      logic [SCORE_W-1:0] up;
      logic [SCORE_W-1:0] cell_val;
      n = span();
      diag = '0;
      left = '0;
      for (int unsigned j = 0; j < n; j++) begin
        up = score_row[j];
        if (second_string[j] == c) begin
          cell_val = diag + SCORE_W'(1);
        end else begin
          cell_val = (up > left) ? up : left;
        end
        diag = up;
        score_row[j] = cell_val;
        left = cell_val;
      end
    endfunction

    // accepted input item
    function void take_item(logic [KIND_W-1:0] kind, logic [SYMBOL_W-1:0] symbol,
                            logic [POSITION_W-1:0] position);
      int unsigned n;
      items_seen++;
      case (kind)
        lcs_pkg::OP_LOAD: begin
          second_string[position] = symbol;
          loaded[position] = 1'b1;
          loads++;
        end
        lcs_pkg::OP_BYTE: begin
          sweep(symbol);
          bytes_swept++;
        end
        lcs_pkg::OP_FINISH: begin
          n = span();
          pending_lengths.push_back((n > 0) ? score_row[n-1] : '0);
          foreach (score_row[j]) score_row[j] = '0;
        end
        default: ;
      endcase
    endfunction

    // accepted result item against the oldest expected length
    function void compare_length(logic [15:0] got);
      logic [SCORE_W-1:0] want;
      if (pending_lengths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected length item at %0t: got %0d", $time, got);
        return;
      end
      want = pending_lengths.pop_front();
      reports++;
      if (got !== 16'(want)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("length mismatch at %0t: expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_COMB} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  lcs_length_calc       calc = new();
  int unsigned          burst_left = 0;
  int unsigned          hold_req = 0;
  int unsigned          hold_done = 0;
  int unsigned          length_writes = 0;
  logic [SYMBOL_W-1:0]  alphabet [4];

  lcs_length_dp_top #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * 3_000_000);
    $display("Verification failed");
    $finish;
  end

  // result side: stall patterns, one long hold-off on request
  initial begin : result_sink
    int unsigned seg_left;
    int unsigned hold_left;
    sink_mode_t  mode;
    seg_left = 0;
    hold_left = 0;
    mode = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) calc.compare_length(m_tdata);
      if (hold_left == 0 && hold_req != hold_done) begin
        hold_left = LONG_HOLD;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 300);
        end
        seg_left--;
        case (mode)
          SINK_OPEN:   m_tready <= 1'b1;
          SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
          SINK_COMB:   m_tready <= (seg_left % 4) != 0;
          default:     m_tready <= 1'b1;
        endcase
      end
    end
  end

  // offer one item, hold it until taken, then maybe pause between bursts
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYMBOL_W-1:0] symbol,
                           input logic [POSITION_W-1:0] position);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'b0, position, symbol};
    do @(posedge clk); while (!s_tready);
    calc.take_item(kind, symbol, position);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(40, 80);
        gap = 0;
      end else begin
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 25);
        if ($urandom_range(0, 19) == 0) gap = $urandom_range(100, 1100);
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every length has come back and the block has had time to go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (calc.pending_lengths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [10:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    calc.length_reg = value;
    length_writes++;
  endtask

  // mostly symbols from a small alphabet so that matches are common
  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 3)];
    return SYMBOL_W'($urandom_range(0, 255));
  endfunction

  // load every cell in use that was never written
  task automatic fill_store(input int unsigned n);
    for (int unsigned p = 0; p < n; p++) begin
      if (!calc.loaded[p]) send_item(lcs_pkg::OP_LOAD, pick_symbol(), POSITION_W'(p));
    end
  endtask

  // first strings with random content, most ended by a finish, with loads and noise mixed in
  task automatic run_strings(input int unsigned budget, input int unsigned max_bytes);
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    int unsigned cells;
    sent = 0;
    cells = calc.span();
    while (sent < budget) begin
      n = $urandom_range(0, max_bytes);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 6 && cells > 0) begin
          send_item(lcs_pkg::OP_LOAD, pick_symbol(),
                    POSITION_W'($urandom_range(0, cells - 1)));
        end else if (r < 9) begin
          send_item(lcs_pkg::OP_LOAD, pick_symbol(),
                    POSITION_W'($urandom_range(0, MAX_LEN - 1)));
        end else if (r < 11) begin
          send_item(KIND_UNUSED, SYMBOL_W'($urandom_range(0, 255)),
                    POSITION_W'($urandom_range(0, MAX_LEN - 1)));
          sent--;
        end else begin
          send_item(lcs_pkg::OP_BYTE, pick_symbol(),
                    POSITION_W'($urandom_range(0, MAX_LEN - 1)));
        end
        sent++;
      end
      // now and then a string runs on without its finish
      if ($urandom_range(0, 9) != 0) begin
        send_item(lcs_pkg::OP_FINISH, SYMBOL_W'($urandom_range(0, 255)),
                  POSITION_W'($urandom_range(0, MAX_LEN - 1)));
        sent++;
      end
    end
  endtask

  // one length setting: idle, write, fresh alphabet, load, strings
  task automatic length_phase(input logic [10:0] value, input int unsigned budget,
                              input int unsigned max_bytes, input bit squeeze);
    settle();
    write_length(value);
    foreach (alphabet[i]) alphabet[i] = SYMBOL_W'($urandom_range(0, 255));
    fill_store(calc.span());
    // results held back while the sender keeps offering, so the block backs up
    if (squeeze) begin
      hold_req++;
      repeat (6) begin
        send_item(lcs_pkg::OP_BYTE, pick_symbol(),
                  POSITION_W'($urandom_range(0, MAX_LEN - 1)));
        send_item(lcs_pkg::OP_FINISH, SYMBOL_W'($urandom_range(0, 255)),
                  POSITION_W'($urandom_range(0, MAX_LEN - 1)));
      end
    end
    run_strings(budget, max_bytes);
  endtask

  // stimulus
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty second string after reset: bytes change nothing, finish reports zero
    send_item(lcs_pkg::OP_BYTE, 8'h5A, 10'h000);
    send_item(KIND_UNUSED, 8'hFF, 10'h3FF);
    send_item(lcs_pkg::OP_FINISH, 8'h00, 10'h000);

    // short second string with extreme symbols, plus a load at the top position
    settle();
    write_length(11'd4);
    send_item(lcs_pkg::OP_LOAD, 8'h00, 10'd0);
    send_item(lcs_pkg::OP_LOAD, 8'hFF, 10'd1);
    send_item(lcs_pkg::OP_LOAD, 8'h41, 10'd2);
    send_item(lcs_pkg::OP_LOAD, 8'hFF, 10'd3);
    send_item(lcs_pkg::OP_LOAD, 8'hAA, 10'h3FF);
    send_item(lcs_pkg::OP_BYTE, 8'hFF, 10'h000);
    send_item(lcs_pkg::OP_BYTE, 8'h00, 10'h155);
    send_item(lcs_pkg::OP_BYTE, 8'h41, 10'h2AA);
    send_item(lcs_pkg::OP_BYTE, 8'hFF, 10'h3FF);
    // unused fields on a finish are ignored, and the row starts clean afterwards
    send_item(lcs_pkg::OP_FINISH, 8'hFF, 10'h3FF);
    send_item(lcs_pkg::OP_BYTE, 8'h41, 10'h3FF);
    send_item(lcs_pkg::OP_FINISH, 8'h00, 10'h000);

    // length shortened in the middle of a string: row kept, new length used
    send_item(lcs_pkg::OP_BYTE, 8'h00, 10'h000);
    send_item(lcs_pkg::OP_BYTE, 8'hFF, 10'h000);
    settle();
    write_length(11'd2);
    send_item(lcs_pkg::OP_BYTE, 8'hFF, 10'h000);
    send_item(lcs_pkg::OP_FINISH, 8'h00, 10'h000);

    // random part over several lengths
    length_phase(11'd1, 70, 6, 1'b0);
    length_phase(11'($urandom_range(2, 6)), 100, 14, 1'b0);
    length_phase(11'($urandom_range(7, 24)), 90, 24, 1'b0);
    length_phase(11'($urandom_range(2, 10)), 60, 12, 1'b1);

    // full store and beyond: finishes and loads only, as a sweep would read
    // bytes that were never loaded
    settle();
    write_length(11'd1024);
    send_item(lcs_pkg::OP_LOAD, 8'h3C, 10'h3FF);
    send_item(lcs_pkg::OP_FINISH, 8'h00, 10'h000);
    settle();
    write_length(11'd2047);
    send_item(lcs_pkg::OP_FINISH, 8'hFF, 10'h3FF);

    length_phase(11'($urandom_range(25, 64)), 80, 24, 1'b0);
    length_phase(11'd0, 30, 6, 1'b0);
    length_phase(11'($urandom_range(1, 12)), 70, 18, 1'b0);

    // drain, then give any stray result time to show up
    settle();
    $display("Covered %0d items: %0d loads, %0d first-string bytes, %0d lengths reported,",
             calc.items_seen, calc.loads, calc.bytes_swept, calc.reports);
    $display("over %0d length settings incl. zero, full store and beyond; %0d mismatches",
             length_writes, calc.mismatches);
    if (calc.pending_lengths.size() != 0)
      $display("%0d lengths never reported", calc.pending_lengths.size());
    if (calc.mismatches == 0 && calc.pending_lengths.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
